[hdl/rws_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Radial wave sample package
// Widths, register codes, reset values and shared types of the wave sampler.
// ----------------------------------------------------------------------------
package rws_pkg;

	localparam int COORD_BITS    = 12;
	localparam int MAX_HALF_WAVE = 1024;
	localparam int SINE_STEPS    = 1024;
	localparam int IDX_W         = $clog2(SINE_STEPS);
	localparam int SINE_W        = 15;
	localparam int AMP_W         = 7;
	localparam int LEN_W         = 11;
	localparam int PER_W         = LEN_W + 1;
	localparam int TIME_W        = 32;
	localparam int SHIFT_W       = 23;
	localparam int DIST_W        = COORD_BITS + 1;
	localparam int SUM_W         = 2 * DIST_W;
	localparam int X_W           = DIST_W + 1;
	localparam int ALU_W         = 16;
	localparam int MUL_A_W       = 32;
	localparam int MUL_B_W       = 29;
	localparam int PROD_W        = MUL_A_W + MUL_B_W;
	localparam int OUT_W         = 8;
	localparam int DATA_W        = 32;
	localparam int REG_ADDR_W    = 4;
	localparam int REG_IDX_W     = 2;
	localparam int RECIP_SHIFT   = 38;

	// Multiplying by this and shifting right by RECIP_SHIFT divides a 32-bit
	// count of milliseconds by 1000 exactly.
	localparam logic [MUL_B_W-1:0] TIME_RECIP = 29'h10624DD3;

	localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

	localparam logic [REG_IDX_W-1:0] REG_CENTER_X  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_Y  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_HALF_WAVE = 2'd3;

	localparam logic [AMP_W-1:0] AMP_RESET       = 7'd64;
	localparam logic [LEN_W-1:0] HALF_WAVE_RESET = 11'd16;

	typedef struct packed {
		logic [COORD_BITS-1:0] center_x;
		logic [COORD_BITS-1:0] center_y;
		logic [AMP_W-1:0]      amplitude;
		logic [LEN_W-1:0]      half_wavelength;
	} rws_cfg_t;

	typedef struct packed {
		logic [MUL_A_W-1:0] mul_a;
		logic [MUL_B_W-1:0] mul_b;
		logic [ALU_W-1:0]   sub_a;
		logic [ALU_W-1:0]   sub_b;
	} rws_alu_req_t;

	typedef struct packed {
		logic [PROD_W-1:0] prod;
		logic [ALU_W-1:0]  diff;
		logic              ge;
	} rws_alu_rsp_t;

endpackage
`default_nettype wire

[hdl/rws_alu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Radial wave sample arithmetic unit
// One multiplier and one compare-and-subtract stage, shared by all steps.
// ----------------------------------------------------------------------------
module rws_alu (
	input  rws_pkg::rws_alu_req_t req,
	output rws_pkg::rws_alu_rsp_t rsp
);
	import rws_pkg::*;

	logic [ALU_W:0] sub_full;

	assign sub_full = {1'b0, req.sub_a} - {1'b0, req.sub_b};

	always_comb begin
		rsp.prod = PROD_W'(req.mul_a) * PROD_W'(req.mul_b);
		rsp.diff = sub_full[ALU_W-1:0];
		rsp.ge   = ~sub_full[ALU_W];
	end

endmodule
`default_nettype wire

[hdl/rws_sine_rom.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Radial wave sample half-sine ROM
// Half a sine period in Q0.15, built at elaboration, read through a register.
// ----------------------------------------------------------------------------
module rws_sine_rom (
	input  logic                       clk,
	input  logic [rws_pkg::IDX_W-1:0]  addr,
	output logic [rws_pkg::SINE_W-1:0] data
);
	import rws_pkg::*;

	typedef logic [SINE_W-1:0] sine_tab_t [SINE_STEPS];

	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] a0, a1, b0, b1, p00, p01, p10, p11, mid, lo, hi;
		a0  = {32'b0, a[31:0]};
		a1  = {32'b0, a[63:32]};
		b0  = {32'b0, b[31:0]};
		b1  = {32'b0, b[63:32]};
		p00 = a0 * b0;
		p01 = a0 * b1;
		p10 = a1 * b0;
		p11 = a1 * b1;
		mid = {32'b0, p00[63:32]} + {32'b0, p01[31:0]} + {32'b0, p10[31:0]};
		lo  = {mid[31:0], p00[31:0]};
		hi  = p11 + {32'b0, p01[63:32]} + {32'b0, p10[63:32]} + {32'b0, mid[63:32]};
		return {hi[61:0], 2'b00} | {62'b0, lo[63:62]};
	endfunction

	// Taylor series in Q2.62, rounded half up to Q0.15 and saturated.
	function automatic logic [SINE_W-1:0] sine_entry(input int k);
		logic [63:0] kk, x, x2, term, sum, r;
		int n;
		kk   = (2 * k > SINE_STEPS) ? 64'(SINE_STEPS - k) : 64'(k);
		x    = (PI_Q62 / SINE_STEPS) * kk + ((PI_Q62 % SINE_STEPS) * kk) / SINE_STEPS;
		x2   = mul_q62(x, x);
		term = x;
		sum  = x;
		for (n = 3; n < 60 && term != 64'd0; n += 2) begin
			term = mul_q62(term, x2) / 64'(n * (n - 1));
			if (n[1]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		r = (sum + 64'h0000_4000_0000_0000) >> 47;
		if (r > 64'd32767) begin
			r = 64'd32767;
		end
		return r[SINE_W-1:0];
	endfunction

	function automatic sine_tab_t build_table();
		sine_tab_t t;
		for (int k = 0; k < SINE_STEPS; k++) begin
			t[k] = sine_entry(k);
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = build_table();

	logic [SINE_W-1:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= SINE_TAB[addr];
	end

	assign data = data_q;

endmodule
`default_nettype wire

[hdl/rws_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Radial wave sample register file
// APB-style configuration registers for emitter position, amplitude and L.
// ----------------------------------------------------------------------------
module rws_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rws_pkg::REG_ADDR_W-1:0] paddr,
	input  logic [rws_pkg::DATA_W-1:0]     pwdata,
	output logic [rws_pkg::DATA_W-1:0]     prdata,
	output rws_pkg::rws_cfg_t              cfg
);
	import rws_pkg::*;

	rws_cfg_t              cfg_q;
	logic [REG_IDX_W-1:0]  reg_idx;

	assign reg_idx = paddr[REG_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x        <= '0;
			cfg_q.center_y        <= '0;
			cfg_q.amplitude       <= AMP_RESET;
			cfg_q.half_wavelength <= HALF_WAVE_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_CENTER_X: begin
					cfg_q.center_x <= pwdata[COORD_BITS-1:0];
				end
				REG_CENTER_Y: begin
					cfg_q.center_y <= pwdata[COORD_BITS-1:0];
				end
				REG_AMPLITUDE: begin
					cfg_q.amplitude <= pwdata[AMP_W-1:0];
				end
				REG_HALF_WAVE: begin
					cfg_q.half_wavelength <= pwdata[LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CENTER_X:  prdata = DATA_W'(cfg_q.center_x);
			REG_CENTER_Y:  prdata = DATA_W'(cfg_q.center_y);
			REG_AMPLITUDE: prdata = DATA_W'(cfg_q.amplitude);
			REG_HALF_WAVE: prdata = DATA_W'(cfg_q.half_wavelength);
			default:       prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[hdl/radial_wave_sample_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Radial wave sample unit
// Height of a circular wave at one pixel, computed on one shared unit.
// ----------------------------------------------------------------------------
// An input beat carries a pixel position and a time in milliseconds; each
// one yields a single output beat with the signed wave height at that pixel.
// The emitter position, amplitude and half wavelength are set through the
// APB port; the user is to write them only while the unit is idle, and the
// unit itself does not enforce this. pready is always high. After an input
// beat is taken, the sequencer runs the multiplier passes, then on the single
// compare-and-subtract unit 13 square-root steps, 23 remainder steps on the
// seconds count, 14 remainder steps on the phase, a reduction step and 10
// steps of the sine index division, then the ROM read and a last multiplier
// pass, and writes the result to the output register. The next input beat
// is taken only once the sequencer is back in idle.
// The output register holds its beat while out_ready is low; a new input
// beat is taken meanwhile, and the sequencer waits at its final step until
// the register is free. Reset returns the sequencer to idle, drops out_valid
// and loads the register reset values.
// ----------------------------------------------------------------------------
module radial_wave_sample_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [rws_pkg::COORD_BITS-1:0]        pixel_x,
	input  logic [rws_pkg::COORD_BITS-1:0]        pixel_y,
	input  logic [rws_pkg::TIME_W-1:0]            time_ms,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [rws_pkg::OUT_W-1:0]      wave_value,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [rws_pkg::REG_ADDR_W-1:0]        paddr,
	input  logic [rws_pkg::DATA_W-1:0]            pwdata,
	output logic [rws_pkg::DATA_W-1:0]            prdata,
	output logic                                  pready
);
	import rws_pkg::*;

	localparam int SQRT_STEPS = SUM_W / 2;
	localparam int CNT_W      = $clog2(SHIFT_W);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL_T = 4'd1;
	localparam logic [3:0] ST_MUL_X = 4'd2;
	localparam logic [3:0] ST_MUL_Y = 4'd3;
	localparam logic [3:0] ST_SQRT  = 4'd4;
	localparam logic [3:0] ST_SMOD  = 4'd5;
	localparam logic [3:0] ST_DSET  = 4'd6;
	localparam logic [3:0] ST_DMOD  = 4'd7;
	localparam logic [3:0] ST_IRED  = 4'd8;
	localparam logic [3:0] ST_IDIV  = 4'd9;
	localparam logic [3:0] ST_ROM   = 4'd10;
	localparam logic [3:0] ST_MUL_A = 4'd11;

	rws_cfg_t     cfg;
	rws_alu_req_t alu_req;
	rws_alu_rsp_t alu_rsp;

	logic [3:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  out_valid_q;
	logic                  out_free;

	logic [TIME_W-1:0]     time_q;
	logic [COORD_BITS-1:0] dx_q, dy_q;
	logic [LEN_W-1:0]      len_q;
	logic [PER_W-1:0]      period_q;
	logic [AMP_W-1:0]      amp_q;
	logic [SHIFT_W-1:0]    shift_q;
	logic [SUM_W-1:0]      sum_q;
	logic [DIST_W-1:0]     root_q;
	logic [ALU_W-1:0]      rem_q;
	logic [X_W-1:0]        x_q;
	logic                  neg_q;
	logic [IDX_W-1:0]      idx_q;
	logic [OUT_W-1:0]      wave_q;

	logic [COORD_BITS-1:0] dx_in, dy_in;
	logic [LEN_W-1:0]      len_cfg;
	logic [SINE_W-1:0]     sine_data;
	logic [AMP_W-1:0]      mag;
	logic [ALU_W-1:0]      step_rem;

	rws_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	rws_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	rws_sine_rom u_rom (
		.clk  (clk),
		.addr (idx_q),
		.data (sine_data)
	);

	assign pready    = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign wave_value = wave_q;
	assign out_free  = !out_valid_q || out_ready;

	assign dx_in = (pixel_x > cfg.center_x) ? pixel_x - cfg.center_x : cfg.center_x - pixel_x;
	assign dy_in = (pixel_y > cfg.center_y) ? pixel_y - cfg.center_y : cfg.center_y - pixel_y;

	always_comb begin
		if (cfg.half_wavelength == '0) begin
			len_cfg = LEN_W'(1);
		end else if (cfg.half_wavelength > LEN_W'(MAX_HALF_WAVE)) begin
			len_cfg = LEN_W'(MAX_HALF_WAVE);
		end else begin
			len_cfg = cfg.half_wavelength;
		end
	end

	assign step_rem = alu_rsp.ge ? alu_rsp.diff : alu_req.sub_a;
	assign mag      = alu_rsp.prod[SINE_W +: AMP_W];

	always_comb begin
		alu_req = '0;
		case (state_q)
			ST_MUL_T: begin
				alu_req.mul_a = time_q;
				alu_req.mul_b = TIME_RECIP;
			end
			ST_MUL_X: begin
				alu_req.mul_a = MUL_A_W'(dx_q);
				alu_req.mul_b = MUL_B_W'(dx_q);
			end
			ST_MUL_Y: begin
				alu_req.mul_a = MUL_A_W'(dy_q);
				alu_req.mul_b = MUL_B_W'(dy_q);
			end
			ST_SQRT: begin
				alu_req.sub_a = {rem_q[ALU_W-3:0], sum_q[SUM_W-1 -: 2]};
				alu_req.sub_b = ALU_W'({root_q, 2'b01});
			end
			ST_SMOD: begin
				alu_req.sub_a = ALU_W'({rem_q[LEN_W-1:0], shift_q[SHIFT_W-1]});
				alu_req.sub_b = ALU_W'(period_q);
			end
			ST_DMOD: begin
				alu_req.sub_a = ALU_W'({rem_q[LEN_W-1:0], x_q[X_W-1]});
				alu_req.sub_b = ALU_W'(period_q);
			end
			ST_IRED: begin
				alu_req.sub_a = rem_q;
				alu_req.sub_b = ALU_W'(len_q);
			end
			ST_IDIV: begin
				alu_req.sub_a = ALU_W'({rem_q[LEN_W-1:0], 1'b0});
				alu_req.sub_b = ALU_W'(len_q);
			end
			ST_MUL_A: begin
				alu_req.mul_a = MUL_A_W'(amp_q);
				alu_req.mul_b = MUL_B_W'(sine_data);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_MUL_A && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL_T;
					end
				end
				ST_MUL_T: begin
					state_q <= ST_MUL_X;
				end
				ST_MUL_X: begin
					state_q <= ST_MUL_Y;
				end
				ST_MUL_Y: begin
					state_q <= ST_SQRT;
					cnt_q   <= CNT_W'(SQRT_STEPS - 1);
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= ST_SMOD;
						cnt_q   <= CNT_W'(SHIFT_W - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SMOD: begin
					if (cnt_q == '0) begin
						state_q <= ST_DSET;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DSET: begin
					state_q <= ST_DMOD;
					cnt_q   <= CNT_W'(X_W - 1);
				end
				ST_DMOD: begin
					if (cnt_q == '0) begin
						state_q <= ST_IRED;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_IRED: begin
					state_q <= ST_IDIV;
					cnt_q   <= CNT_W'(IDX_W - 1);
				end
				ST_IDIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_ROM;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_ROM: begin
					state_q <= ST_MUL_A;
				end
				ST_MUL_A: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					time_q   <= time_ms;
					dx_q     <= dx_in;
					dy_q     <= dy_in;
					len_q    <= len_cfg;
					period_q <= {len_cfg, 1'b0};
					amp_q    <= cfg.amplitude;
				end
			end
			ST_MUL_T: begin
				shift_q <= alu_rsp.prod[RECIP_SHIFT +: SHIFT_W];
			end
			ST_MUL_X: begin
				sum_q <= SUM_W'(alu_rsp.prod[2*COORD_BITS-1:0]);
			end
			ST_MUL_Y: begin
				sum_q  <= sum_q + SUM_W'(alu_rsp.prod[2*COORD_BITS-1:0]);
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				root_q <= {root_q[DIST_W-2:0], alu_rsp.ge};
				sum_q  <= {sum_q[SUM_W-3:0], 2'b00};
				if (cnt_q == '0) begin
					rem_q <= '0;
				end else begin
					rem_q <= step_rem;
				end
			end
			ST_SMOD: begin
				rem_q   <= step_rem;
				shift_q <= {shift_q[SHIFT_W-2:0], 1'b0};
			end
			ST_DSET: begin
				x_q   <= X_W'(root_q) + X_W'(period_q) - X_W'(rem_q[LEN_W-1:0]);
				rem_q <= '0;
			end
			ST_DMOD: begin
				rem_q <= step_rem;
				x_q   <= {x_q[X_W-2:0], 1'b0};
			end
			ST_IRED: begin
				neg_q <= alu_rsp.ge;
				if (alu_rsp.ge) begin
					rem_q <= alu_rsp.diff;
				end
			end
			ST_IDIV: begin
				rem_q <= step_rem;
				idx_q <= {idx_q[IDX_W-2:0], alu_rsp.ge};
			end
			ST_MUL_A: begin
				if (out_free) begin
					if (neg_q) begin
						wave_q <= OUT_W'(-{1'b0, mag});
					end else begin
						wave_q <= OUT_W'({1'b0, mag});
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

[sim/tb_radial_wave_sample_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial wave sample unit testbench
// Drives pixel beats and APB register writes into the wave sampler, predicts
// each wave height from its own copy of the registers and an integer-built
// half-sine table, and compares every output beat in order of arrival.
// Runs a directed set of corner cases and then random phases that differ in
// register settings and in how often each side of the stream idles.
// ----------------------------------------------------------------------------
module tb_radial_wave_sample_unit;
	import rws_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE      = 80;
	localparam int PHASE_BEATS = 60;

	class wave_predictor;
		bit [15:0]             sine_rom [SINE_STEPS];
		bit [COORD_BITS-1:0]   cx;
		bit [COORD_BITS-1:0]   cy;
		bit [AMP_W-1:0]        amp;
		bit [LEN_W-1:0]        half_len;
		logic [OUT_W-1:0]      pending_heights [$];
		int                    mismatches;
		int                    checked;

		function new();
			cx = '0;
			cy = '0;
			amp = AMP_RESET;
			half_len = HALF_WAVE_RESET;
			mismatches = 0;
			checked = 0;
			for (int k = 0; k < SINE_STEPS; k++) begin
				sine_rom[k] = sine_at(k);
			end
		endfunction

		function bit [63:0] q62_mul(bit [63:0] a, bit [63:0] b);
			bit [127:0] p;
			p = {64'd0, a} * {64'd0, b};
			return p[125:62];
		endfunction

		// Taylor series of sin in Q2.62, rounded to Q1.15.
		function bit [15:0] sine_at(int k);
			bit [63:0] kk;
			bit [63:0] x;
			bit [63:0] x2;
			bit [63:0] term;
			bit [63:0] acc;
			bit [63:0] r;
			bit [63:0] n;
			kk = (2 * k > SINE_STEPS) ? 64'(SINE_STEPS - k) : 64'(k);
			x = (PI_Q62 / SINE_STEPS) * kk + ((PI_Q62 % SINE_STEPS) * kk) / SINE_STEPS;
			x2 = q62_mul(x, x);
			term = x;
			acc = x;
			for (n = 3; n < 60 && term != 0; n += 2) begin
				term = q62_mul(term, x2) / (n * (n - 1));
				if (((n - 1) / 2) & 64'd1) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
			r = (acc + (64'd1 << 46)) >> 47;
			if (r > 64'd32767) begin
				r = 64'd32767;
			end
			return r[15:0];
		endfunction

		function bit [31:0] root_floor(bit [31:0] v);
			bit [31:0] res;
			bit [31:0] probe;
			res = '0;
			probe = 32'd1 << 30;
			while (probe > v) begin
				probe >>= 2;
			end
			while (probe != 0) begin
				if (v >= res + probe) begin
					v = v - (res + probe);
					res = (res >> 1) + probe;
				end else begin
					res >>= 1;
				end
				probe >>= 2;
			end
			return res;
		endfunction

		function void set_register(bit [REG_IDX_W-1:0] idx, bit [DATA_W-1:0] value);
			case (idx)
				REG_CENTER_X:  cx = value[COORD_BITS-1:0];
				REG_CENTER_Y:  cy = value[COORD_BITS-1:0];
				REG_AMPLITUDE: amp = value[AMP_W-1:0];
				REG_HALF_WAVE: half_len = value[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_pixel(bit [COORD_BITS-1:0] px, bit [COORD_BITS-1:0] py,
				bit [TIME_W-1:0] t);
			bit [31:0] dx;
			bit [31:0] dy;
			bit [31:0] radius;
			bit [31:0] secs;
			bit [31:0] len;
			bit [31:0] period;
			bit [31:0] d;
			bit [31:0] i;
			bit [31:0] idx;
			bit [31:0] mag;
			dx = (px > cx) ? px - cx : cx - px;
			dy = (py > cy) ? py - cy : cy - py;
			radius = root_floor(dx * dx + dy * dy);
			secs = t / 32'd1000;
			if (half_len == 0) begin
				len = 1;
			end else if (half_len > MAX_HALF_WAVE) begin
				len = MAX_HALF_WAVE;
			end else begin
				len = half_len;
			end
			period = 2 * len;
			d = (radius % period + period - secs % period) % period;
			i = (d >= len) ? d - len : d;
			idx = i * SINE_STEPS / len;
			if (idx >= SINE_STEPS) begin
				idx = SINE_STEPS - 1;
			end
			mag = (32'(amp) * 32'(sine_rom[idx])) >> 15;
			pending_heights.push_back((d >= len) ? 8'(-mag) : mag[OUT_W-1:0]);
		endfunction

		function void check_height(logic [OUT_W-1:0] got);
			logic [OUT_W-1:0] want;
			checked++;
			if (pending_heights.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Output beat %0d arrived with no pixel pending: %0d",
						checked, $signed(got));
				end
			end else begin
				want = pending_heights.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Output beat %0d: wave_value expected %0d, got %0d",
							checked, $signed(want), $signed(got));
					end
				end
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [COORD_BITS-1:0]        pixel_x;
	logic [COORD_BITS-1:0]        pixel_y;
	logic [TIME_W-1:0]            time_ms;
	logic                         out_valid;
	logic                         out_ready;
	logic signed [OUT_W-1:0]      wave_value;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [REG_ADDR_W-1:0]        paddr;
	logic [DATA_W-1:0]            pwdata;
	logic [DATA_W-1:0]            prdata;
	logic                         pready;

	wave_predictor book;
	int gap_pct;
	int stall_pct;
	int hold_request;
	int hold_left;
	int pixels_sent;
	int settings_used;
	int cycle_count;

	radial_wave_sample_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.time_ms    (time_ms),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.wave_value (wave_value),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			book.take_pixel(pixel_x, pixel_y, time_ms);
		end
		if (arst_n && out_valid && out_ready) begin
			book.check_height(wave_value);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles with %0d beats still pending.",
			cycle_count, book.pending_heights.size());
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [COORD_BITS-1:0] near_coord(bit [COORD_BITS-1:0] c);
		int v;
		v = int'(c) + int'($urandom_range(80)) - 40;
		if (v < 0) begin
			v = 0;
		end else if (v > 4095) begin
			v = 4095;
		end
		return v[COORD_BITS-1:0];
	endfunction

	task automatic send_pixel(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
			input logic [TIME_W-1:0] t);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_x <= px;
		pixel_y <= py;
		time_ms <= t;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		pixels_sent++;
	endtask

	task automatic wait_all_heights(input int settle);
		in_valid <= 1'b0;
		while (book.pending_heights.size() != 0) begin
			@(negedge clk);
		end
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		book.set_register(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
			input logic [AMP_W-1:0] amp, input logic [LEN_W-1:0] len);
		wait_all_heights(SETTLE);
		write_reg(REG_CENTER_X, {20'($urandom), cx});
		write_reg(REG_CENTER_Y, {20'($urandom), cy});
		write_reg(REG_AMPLITUDE, {25'($urandom), amp});
		write_reg(REG_HALF_WAVE, {21'($urandom), len});
		settings_used++;
	endtask

	initial begin
		logic [COORD_BITS-1:0] rcx;
		logic [COORD_BITS-1:0] rcy;
		logic [AMP_W-1:0]      ramp;
		logic [LEN_W-1:0]      rlen;
		logic [COORD_BITS-1:0] px;
		logic [COORD_BITS-1:0] py;
		logic [TIME_W-1:0]     t;

		book = new();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		pixel_x = '0;
		pixel_y = '0;
		time_ms = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		gap_pct = 0;
		stall_pct = 0;
		hold_request = 0;
		hold_left = 0;
		pixels_sent = 0;
		settings_used = 1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_pixel(12'd0, 12'd0, 32'd0);
		send_pixel(12'd4095, 12'd4095, 32'd0);
		send_pixel(12'd4095, 12'd0, 32'd999);
		send_pixel(12'd0, 12'd4095, 32'd1000);
		send_pixel(12'd16, 12'd0, 32'd0);
		send_pixel(12'd8, 12'd0, 32'hFFFFFFFF);
		send_pixel(12'd3, 12'd4, 32'd15999);
		send_pixel(12'd4095, 12'd4095, 32'hFFFFFFFF);

		configure(12'd4095, 12'd4095, 7'd127, 11'd1024);
		send_pixel(12'd0, 12'd0, 32'd0);
		send_pixel(12'd4095, 12'd4095, 32'd0);
		send_pixel(12'd0, 12'd4095, 32'hFFFFFFFF);
		send_pixel(12'd2048, 12'd4095, 32'd999);
		send_pixel(12'd1000, 12'd1000, 32'd1000000);

		configure(12'd100, 12'd200, 7'd127, 11'd0);
		send_pixel(12'd100, 12'd200, 32'd0);
		send_pixel(12'd101, 12'd200, 32'd1000);
		send_pixel(12'd4095, 12'd0, 32'd5000);

		configure(12'd2048, 12'd2048, 7'd0, 11'd2047);
		send_pixel(12'd0, 12'd0, 32'd0);
		send_pixel(12'd4095, 12'd4095, 32'd7);

		configure(12'd0, 12'd0, 7'd127, 11'd1);
		send_pixel(12'd1, 12'd0, 32'd0);
		send_pixel(12'd0, 12'd0, 32'd1000);

		configure(12'd0, 12'd4095, 7'd127, 11'd1025);
		send_pixel(12'd4095, 12'd0, 32'd0);
		send_pixel(12'd2000, 12'd3000, 32'd123456);

		for (int phase = 0; phase < 8; phase++) begin
			rcx = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 12'd4095 : 12'd0)
				: 12'($urandom_range(4095));
			rcy = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 12'd4095 : 12'd0)
				: 12'($urandom_range(4095));
			case ($urandom_range(4))
				0: ramp = 7'd0;
				1: ramp = 7'd127;
				default: ramp = 7'($urandom_range(127));
			endcase
			case ($urandom_range(7))
				0: rlen = 11'd0;
				1: rlen = 11'd1;
				2: rlen = 11'd1024;
				3: rlen = 11'd2047;
				4: rlen = 11'($urandom_range(2047, 1025));
				5, 6: rlen = 11'($urandom_range(64, 2));
				default: rlen = 11'($urandom_range(1023, 1));
			endcase
			configure(rcx, rcy, ramp, rlen);
			case (phase % 4)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 57;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 57;
				end
				default: begin
					gap_pct = 6;
					stall_pct = 6;
				end
			endcase
			if (phase == 2) begin
				hold_request = 600;
			end
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (phase == 5 && n == PHASE_BEATS / 2) begin
					wait_all_heights(0);
				end
				if ($urandom_range(2) == 0) begin
					px = near_coord(book.cx);
					py = near_coord(book.cy);
				end else begin
					px = 12'($urandom);
					py = 12'($urandom);
				end
				t = $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(100000));
				send_pixel(px, py, t);
			end
		end

		gap_pct = 0;
		stall_pct = 0;
		wait_all_heights(SETTLE);
		$display("Sent %0d pixel beats and checked %0d wave heights under %0d register settings,",
			pixels_sent, book.checked, settings_used);
		$display("with quiet, sender-gap, receiver-stall, mixed and long-hold traffic.");
		if (book.mismatches == 0 && book.pending_heights.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d heights never arrived.", book.mismatches,
				book.pending_heights.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
